FILE: rtl/acst_pkg.sv
// Shared types, constants and helpers of the ADC channel scan block.
`timescale 1ns / 1ps
package acst_pkg;

   localparam int MAX_CHANNELS = 16;
   localparam int MASK_W       = 16;
   localparam int CODE_W       = 12;
   localparam int GAIN_W       = 18;
   localparam int FRAC_BITS    = 14;
   localparam int FRAC_SCALE   = 1000;
   localparam int SAMPLE_MAX   = 4095;
   localparam int GAIN_VAL_W   = 15;   // 15 * 1000 + 16383 fits
   localparam int PROD_W       = 27;   // 4095 * 31383 fits
   localparam int QPROD_W      = 22;   // products below the clip point
   localparam int RECIP_SHIFT  = 32;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam logic [22:0] RECIP = 23'd4294968;   // ceil(2^32 / 1000)
   localparam logic [PROD_W-1:0] CLIP_PRODUCT = PROD_W'((SAMPLE_MAX + 1) * FRAC_SCALE);
   localparam logic [CODE_W-1:0] CODE_MSB = 12'h800;

   typedef enum logic [1:0] {
      KIND_CONVERT = 2'd0,
      KIND_SAMPLE  = 2'd1,
      KIND_DONE    = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_NUM_CHANNELS  = 3'd0,
      REG_READY_MASK    = 3'd1,
      REG_DIFF_MASK     = 3'd2,
      REG_SINGLE_GAIN   = 3'd3,
      REG_DIFF_GAIN     = 3'd4,
      REG_SINGLE_OFFSET = 3'd5,
      REG_DIFF_OFFSET   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [4:0]        num_channels;
      logic [MASK_W-1:0] ready_mask;
      logic [MASK_W-1:0] diff_mask;
      logic [GAIN_W-1:0] single_gain_word;
      logic [GAIN_W-1:0] diff_gain_word;
      logic [15:0]       single_offset;
      logic [15:0]       diff_offset;
   } cfg_type;

   // Work handed from the front to the back end.
   typedef struct packed {
      logic              is_sample;
      kind_type          kind;
      logic [3:0]        channel;
      logic [CODE_W-1:0] raw_code;
      logic              diff;
      kind_type          next_kind;
      logic [3:0]        next_channel;
   } cmd_type;

   typedef struct packed {
      kind_type          kind;
      logic [3:0]        channel;
      logic [CODE_W-1:0] sample;
      logic              last;
   } rsp_type;

   function automatic logic [3:0] lowest_bit(input logic [MASK_W-1:0] m);
      logic [3:0] r;
      r = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (m[i]) begin
            r = 4'(i);
         end
      end
      return r;
   endfunction

endpackage

FILE: rtl/acst_csr.sv
// Configuration register file with the APB-style access port.
`timescale 1ns / 1ps
module acst_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output acst_pkg::cfg_type cfg
);
   import acst_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx        = reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_NUM_CHANNELS:  cfg_in.num_channels     = csr_pwdata[4:0];
            REG_READY_MASK:    cfg_in.ready_mask       = csr_pwdata[15:0];
            REG_DIFF_MASK:     cfg_in.diff_mask        = csr_pwdata[15:0];
            REG_SINGLE_GAIN:   cfg_in.single_gain_word = csr_pwdata[17:0];
            REG_DIFF_GAIN:     cfg_in.diff_gain_word   = csr_pwdata[17:0];
            REG_SINGLE_OFFSET: cfg_in.single_offset    = csr_pwdata[15:0];
            REG_DIFF_OFFSET:   cfg_in.diff_offset      = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_NUM_CHANNELS:  csr_prdata = {27'd0, cfg_ff.num_channels};
         REG_READY_MASK:    csr_prdata = {16'd0, cfg_ff.ready_mask};
         REG_DIFF_MASK:     csr_prdata = {16'd0, cfg_ff.diff_mask};
         REG_SINGLE_GAIN:   csr_prdata = {14'd0, cfg_ff.single_gain_word};
         REG_DIFF_GAIN:     csr_prdata = {14'd0, cfg_ff.diff_gain_word};
         REG_SINGLE_OFFSET: csr_prdata = {16'd0, cfg_ff.single_offset};
         REG_DIFF_OFFSET:   csr_prdata = {16'd0, cfg_ff.diff_offset};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_channels     <= 5'd16;
         cfg_ff.ready_mask       <= '0;
         cfg_ff.diff_mask        <= '0;
         cfg_ff.single_gain_word <= 18'd16384;
         cfg_ff.diff_gain_word   <= 18'd16384;
         cfg_ff.single_offset    <= '0;
         cfg_ff.diff_offset      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/acst_front.sv
// Front end: accepts items, tracks the scan and queues work for the back end.
`timescale 1ns / 1ps
module acst_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_func,
   input  logic [15:0]       req_channel_mask,
   input  logic [11:0]       req_raw_code,
   input  logic              req_intr_ok,
   input  acst_pkg::cfg_type cfg,
   output acst_pkg::cmd_type cmd,
   output logic              cmd_valid,
   input  logic              cmd_take
);
   import acst_pkg::*;

   logic [MASK_W-1:0] pending_ff, pending_in;
   logic [3:0]        active_ff, active_in;
   logic              busy_ff, busy_in;

   cmd_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   logic              accept;
   cmd_type           cmd_new;
   logic [5:0]        lim;
   logic [MASK_W-1:0] allowed;
   logic [MASK_W-1:0] rest;
   logic              bad_mask;

   assign req_full  = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign accept    = req_push && !req_full;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = mem_ff[rd_ptr_ff];

   always_comb begin
      lim = {1'b0, cfg.num_channels};
      if (lim > 6'(MAX_CHANNELS)) begin
         lim = 6'(MAX_CHANNELS);
      end
      if (lim >= 6'(MASK_W)) begin
         allowed = '1;
      end else begin
         allowed = MASK_W'((17'd1 << lim[3:0]) - 17'd1);
      end
      bad_mask = (req_channel_mask == '0) || ((req_channel_mask & ~allowed) != '0)
                 || ((req_channel_mask & ~cfg.ready_mask) != '0);
      rest = pending_ff & ~(MASK_W'(1) << active_ff);
   end

   // Classify the item and advance the scan state at once.
   always_comb begin
      pending_in = pending_ff;
      active_in  = active_ff;
      busy_in    = busy_ff;
      cmd_new    = '0;
      cmd_new.kind = KIND_ERROR;
      if (accept) begin
         if (!req_func) begin
            if (!busy_ff && !bad_mask) begin
               pending_in      = req_channel_mask;
               active_in       = lowest_bit(req_channel_mask);
               busy_in         = 1'b1;
               cmd_new.kind    = KIND_CONVERT;
               cmd_new.channel = lowest_bit(req_channel_mask);
            end
         end else if (busy_ff) begin
            if (!req_intr_ok) begin
               pending_in = '0;
               active_in  = '0;
               busy_in    = 1'b0;
            end else begin
               cmd_new.is_sample = 1'b1;
               cmd_new.kind      = KIND_SAMPLE;
               cmd_new.channel   = active_ff;
               cmd_new.raw_code  = req_raw_code;
               cmd_new.diff      = cfg.diff_mask[active_ff];
               pending_in        = rest;
               if (rest != '0) begin
                  active_in            = lowest_bit(rest);
                  cmd_new.next_kind    = KIND_CONVERT;
                  cmd_new.next_channel = lowest_bit(rest);
               end else begin
                  active_in         = '0;
                  busy_in           = 1'b0;
                  cmd_new.next_kind = KIND_DONE;
               end
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (accept && !(cmd_take && cmd_valid)) begin
         count_in = count_ff + 1'b1;
      end else if (!accept && cmd_take && cmd_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         active_ff  <= '0;
         busy_ff    <= 1'b0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         active_ff  <= active_in;
         busy_ff    <= busy_in;
         count_ff   <= count_in;
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (cmd_take && cmd_valid) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

FILE: rtl/acst_back.sv
// Back end: trim pipeline for samples and the result queue.
`timescale 1ns / 1ps
module acst_back (
   input  logic              clock,
   input  logic              reset,
   input  acst_pkg::cfg_type cfg,
   input  acst_pkg::cmd_type cmd,
   input  logic              cmd_valid,
   output logic              cmd_take,
   output acst_pkg::rsp_type rsp,
   output logic              rsp_empty,
   input  logic              rsp_pop
);
   import acst_pkg::*;

   cmd_type                 s1_ff, s2_ff, s3_ff;
   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [CODE_W-1:0]       d1_ff, d1_in;
   logic [GAIN_VAL_W-1:0]   g1_ff, g1_in;
   logic [PROD_W-1:0]       p2_ff, p2_in;
   logic [CODE_W-1:0]       q3_ff, q3_in;
   logic                    phase_ff, phase_in;

   rsp_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]    count_ff, count_in;

   logic                    out_full, out_wr, out_rd;
   logic                    s3_done, adv3, adv2, adv1;
   rsp_type                 rsp_new;
   logic [CODE_W-1:0]       t;
   logic [15:0]             off;
   logic [GAIN_W-1:0]       gw;
   logic [16:0]             diff_val;
   logic [44:0]             qprod;

   assign out_full  = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign rsp       = mem_ff[rd_ptr_ff];
   assign out_rd    = rsp_pop && !rsp_empty;

   // A sample item leaves two results, one per cycle while the result queue is not full.
   assign out_wr   = s3_valid_ff && !out_full;
   assign s3_done  = out_wr && (!s3_ff.is_sample || phase_ff);
   assign adv3     = !s3_valid_ff || s3_done;
   assign adv2     = !s2_valid_ff || adv3;
   assign adv1     = !s1_valid_ff || adv2;
   assign cmd_take = adv1 && cmd_valid;

   // Stage 1: offset and gain value.
   always_comb begin
      t        = cmd.raw_code ^ CODE_MSB;
      off      = cmd.diff ? cfg.diff_offset : cfg.single_offset;
      gw       = cmd.diff ? cfg.diff_gain_word : cfg.single_gain_word;
      diff_val = {5'd0, t} - {1'b0, off};
      d1_in    = ({4'd0, t} > off) ? diff_val[CODE_W-1:0] : '0;
      g1_in    = GAIN_VAL_W'(gw[GAIN_W-1:FRAC_BITS]) * GAIN_VAL_W'(FRAC_SCALE)
                 + GAIN_VAL_W'(gw[FRAC_BITS-1:0]);
   end

   // Stage 2: scale; stage 3: divide by 1000 through the reciprocal, clip.
   assign p2_in = PROD_W'(d1_ff) * PROD_W'(g1_ff);
   assign qprod = 45'(p2_ff[QPROD_W-1:0]) * 45'(RECIP);
   assign q3_in = (p2_ff >= CLIP_PRODUCT) ? CODE_W'(SAMPLE_MAX)
                                          : qprod[RECIP_SHIFT+CODE_W-1:RECIP_SHIFT];

   always_comb begin
      rsp_new = '0;
      if (!s3_ff.is_sample) begin
         rsp_new.kind    = s3_ff.kind;
         rsp_new.channel = (s3_ff.kind == KIND_CONVERT) ? s3_ff.channel : '0;
         rsp_new.last    = 1'b1;
      end else if (!phase_ff) begin
         rsp_new.kind    = KIND_SAMPLE;
         rsp_new.channel = s3_ff.channel;
         rsp_new.sample  = q3_ff ^ CODE_MSB;
      end else begin
         rsp_new.kind    = s3_ff.next_kind;
         rsp_new.channel = s3_ff.next_channel;
         rsp_new.last    = 1'b1;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (adv3) begin
         phase_in = 1'b0;
      end else if (out_wr) begin
         phase_in = 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (out_wr && !out_rd) begin
         count_in = count_ff + 1'b1;
      end else if (!out_wr && out_rd) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         phase_ff    <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= cmd_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         phase_ff <= phase_in;
         count_ff <= count_in;
         if (out_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (out_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff <= cmd;
         d1_ff <= d1_in;
         g1_ff <= g1_in;
      end
      if (adv2) begin
         s2_ff <= s1_ff;
         p2_ff <= p2_in;
      end
      if (adv3) begin
         s3_ff <= s2_ff;
         q3_ff <= q3_in;
      end
      if (out_wr) begin
         mem_ff[wr_ptr_ff] <= rsp_new;
      end
   end

endmodule

FILE: rtl/adc_channel_scan_with_trim.sv
// Top level of the ADC channel scan controller with per-type trim.
//
// Input channel (req_*): queue-style push/full. A start item (func 0)
// carries a channel mask; a conversion-finished item (func 1) carries the
// raw code and the interrupt status. Result channel (rsp_*): queue-style
// empty/pop; each result carries kind, channel, sample and last.
// A start item or a rejected item gives one result; an accepted
// conversion-finished item gives two (the trimmed sample, then the next
// convert request or scan done).
// An item passes the work queue, the three trim stages and the result
// queue before its first result is on the result ports. Throughput: one
// item per cycle for single-result items while the result queue has
// room; a conversion-finished item holds the pipeline while the single
// write port takes its two results. The trim path is a 3-stage pipeline
// (offset, gain multiply, reciprocal multiply for the divide by 1000 and
// clip). A 4-entry work queue sits between the front end and the back
// end, and a 4-entry result queue at the output; when the receiver
// stalls, both fill and req_full rises. Reset empties both queues, ends
// any scan and loads the register reset values. Registers must be written
// through csr_* only while the block is idle; the user keeps to this.
`timescale 1ns / 1ps
module adc_channel_scan_with_trim (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_func,
   input  logic [15:0] req_channel_mask,
   input  logic [11:0] req_raw_code,
   input  logic        req_intr_ok,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_channel,
   output logic [11:0] rsp_sample,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import acst_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_take;
   rsp_type rsp;

   acst_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   acst_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_channel_mask (req_channel_mask),
      .req_raw_code     (req_raw_code),
      .req_intr_ok      (req_intr_ok),
      .cfg              (cfg),
      .cmd              (cmd),
      .cmd_valid        (cmd_valid),
      .cmd_take         (cmd_take)
   );

   acst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .rsp       (rsp),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_kind    = rsp.kind;
   assign rsp_channel = rsp.channel;
   assign rsp_sample  = rsp.sample;
   assign rsp_last    = rsp.last;

   a_reset_clears: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_sample_not_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_kind == KIND_SAMPLE |-> !rsp_last)
      else $error("sample item marked last");

   a_sample_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_kind != KIND_SAMPLE |-> rsp_sample == '0)
      else $error("nonzero sample on non-sample item");

   a_channel_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_kind == KIND_DONE || rsp_kind == KIND_ERROR) |-> rsp_channel == '0)
      else $error("nonzero channel on done or error item");

endmodule
